[sv/tka_pkg.sv]
package tka_pkg;

   // Fixed field widths of the block.
   localparam int SCORE_W  = 32;
   localparam int CSR_K_W  = 4;
   localparam int APB_DW   = 32;
   localparam int APB_AW   = 2;

   // Defaults for the top-level parameters.
   localparam int MAX_K_DEF   = 8;
   localparam int MAX_LEN_DEF = 16384;

   // Reset value of the k_in_use register.
   localparam logic [CSR_K_W-1:0] K_RESET = 4'd3;

   // Byte addresses of the configuration registers.
   localparam logic [APB_AW-1:0] ADDR_K_IN_USE = 2'd0;

endpackage

[sv/tka_ins_cell.sv]
module tka_ins_cell
   import tka_pkg::*;
#(
   parameter int POS_W = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      clear,
   input  logic signed [SCORE_W-1:0] new_score,
   input  logic [POS_W-1:0]          new_pos,
   input  logic                      prev_gt,
   input  logic signed [SCORE_W-1:0] prev_score,
   input  logic [POS_W-1:0]          prev_pos,
   input  logic                      prev_valid,
   output logic                      gt,
   output logic signed [SCORE_W-1:0] score,
   output logic [POS_W-1:0]          pos,
   output logic                      valid,
   output logic signed [SCORE_W-1:0] nxt_score,
   output logic [POS_W-1:0]          nxt_pos,
   output logic                      nxt_valid
);

   logic signed [SCORE_W-1:0] score_ff;
   logic [POS_W-1:0]          pos_ff;
   logic                      valid_ff;

   // The new score displaces this entry only when strictly larger, so ties keep
   // the earlier position in front.
   assign gt = !valid_ff || (new_score > score_ff);

   // Shift in from the neighbor if the insertion point is above this cell,
   // take the new element if it lands here, else hold.
   always_comb begin
      nxt_score = score_ff;
      nxt_pos   = pos_ff;
      nxt_valid = valid_ff;
      if (prev_gt) begin
         nxt_score = prev_score;
         nxt_pos   = prev_pos;
         nxt_valid = prev_valid;
      end else if (gt) begin
         nxt_score = new_score;
         nxt_pos   = new_pos;
         nxt_valid = 1'b1;
      end
   end

   // Payload follows every accepted element; the end of a vector empties the cell.
   always_ff @(posedge clock) begin
      if (enable) begin
         score_ff <= nxt_score;
         pos_ff   <= nxt_pos;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= clear ? 1'b0 : nxt_valid;
      end
   end

   assign score = score_ff;
   assign pos   = pos_ff;
   assign valid = valid_ff;

endmodule

[sv/tka_out_cell.sv]
module tka_out_cell
   import tka_pkg::*;
#(
   parameter int POS_W = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic                      shift,
   input  logic signed [SCORE_W-1:0] load_score,
   input  logic [POS_W-1:0]          load_pos,
   input  logic                      load_valid,
   input  logic signed [SCORE_W-1:0] next_score,
   input  logic [POS_W-1:0]          next_pos,
   input  logic                      next_valid,
   output logic signed [SCORE_W-1:0] score,
   output logic [POS_W-1:0]          pos,
   output logic                      valid
);

   logic signed [SCORE_W-1:0] score_ff;
   logic [POS_W-1:0]          pos_ff;
   logic                      valid_ff;

   // A finished ranking is loaded in parallel and then moves toward the front
   // one entry per result transfer.
   always_ff @(posedge clock) begin
      if (load) begin
         score_ff <= load_score;
         pos_ff   <= load_pos;
      end else if (shift) begin
         score_ff <= next_score;
         pos_ff   <= next_pos;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= load_valid;
      end else if (shift) begin
         valid_ff <= next_valid;
      end
   end

   assign score = score_ff;
   assign pos   = pos_ff;
   assign valid = valid_ff;

endmodule

[sv/top_k_argmax.sv]
// The first result of a vector is valid in the cycle after its last element's transfer.
// One element per cycle while req_ready is high, set by the compare-and-shift insertion cell chain.
// A vector emits k results from a separate output shift chain, one per cycle while rsp_ready
// is high; the next vector's elements stream in meanwhile, only its last element waits for
// that chain to drain. Reset (synchronous, active high) empties both chains, zeroes the
// position count and sets k_in_use to 3.
module top_k_argmax
   import tka_pkg::*;
#(
   parameter int MAX_K   = MAX_K_DEF,
   parameter int MAX_LEN = MAX_LEN_DEF,
   localparam int POS_W  = $clog2(MAX_LEN),
   localparam int KW     = $clog2(MAX_K + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [SCORE_W-1:0] req_score,
   input  logic                      req_end_of_vector,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [POS_W-1:0]          rsp_position,
   output logic signed [SCORE_W-1:0] rsp_top_score,
   output logic                      rsp_slot_filled,
   output logic                      rsp_last_rank,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [APB_AW-1:0]         paddr,
   input  logic [APB_DW-1:0]         pwdata,
   output logic [APB_DW-1:0]         prdata,
   output logic                      pready
);

   logic [CSR_K_W-1:0] k_ff;
   logic [POS_W-1:0]   count_ff;
   logic [KW-1:0]      remain_ff;
   logic [KW-1:0]      k_eff;

   logic req_xfer, rsp_xfer, end_xfer, pop_last;

   logic                      ins_gt     [MAX_K];
   logic signed [SCORE_W-1:0] ins_score  [MAX_K];
   logic [POS_W-1:0]          ins_pos    [MAX_K];
   logic [MAX_K-1:0]          ins_valid;
   logic signed [SCORE_W-1:0] ins_nscore [MAX_K];
   logic [POS_W-1:0]          ins_npos   [MAX_K];
   logic                      ins_nvalid [MAX_K];

   logic signed [SCORE_W-1:0] out_score  [MAX_K];
   logic [POS_W-1:0]          out_pos    [MAX_K];
   logic                      out_valid  [MAX_K];

   // Handshake terms.
   assign rsp_valid = (remain_ff != '0);
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign pop_last  = rsp_xfer && (remain_ff == KW'(1));
   assign req_ready = !req_end_of_vector || !rsp_valid || pop_last;
   assign req_xfer  = req_valid && req_ready;
   assign end_xfer  = req_xfer && req_end_of_vector;

   // Configuration register write and read.
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= K_RESET;
      end else if (psel && penable && pwrite && (paddr == ADDR_K_IN_USE)) begin
         k_ff <= pwdata[CSR_K_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_K_IN_USE) ? APB_DW'(k_ff) : '0;

   // Clamp the rank count to 1..MAX_K.
   always_comb begin
      if (k_ff == '0) begin
         k_eff = KW'(1);
      end else if (32'(k_ff) > 32'(MAX_K)) begin
         k_eff = KW'(MAX_K);
      end else begin
         k_eff = KW'(k_ff);
      end
   end

   // Position within the vector, saturating at the top of its range.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (end_xfer) begin
         count_ff <= '0;
      end else if (req_xfer && (count_ff != POS_W'(MAX_LEN - 1))) begin
         count_ff <= count_ff + POS_W'(1);
      end
   end

   // Number of results still to deliver for the loaded ranking.
   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else if (end_xfer) begin
         remain_ff <= k_eff;
      end else if (rsp_xfer) begin
         remain_ff <= remain_ff - KW'(1);
      end
   end

   // Insertion chain and output chain, one cell of each per rank.
   for (genvar i = 0; i < MAX_K; i++) begin : g_rank
      logic                      p_gt;
      logic signed [SCORE_W-1:0] p_score;
      logic [POS_W-1:0]          p_pos;
      logic                      p_valid;
      logic signed [SCORE_W-1:0] n_score;
      logic [POS_W-1:0]          n_pos;
      logic                      n_valid;

      if (i == 0) begin : g_head
         assign p_gt    = 1'b0;
         assign p_score = '0;
         assign p_pos   = '0;
         assign p_valid = 1'b0;
      end else begin : g_body
         assign p_gt    = ins_gt[i-1];
         assign p_score = ins_score[i-1];
         assign p_pos   = ins_pos[i-1];
         assign p_valid = ins_valid[i-1];
      end

      if (i == MAX_K - 1) begin : g_tail
         assign n_score = '0;
         assign n_pos   = '0;
         assign n_valid = 1'b0;
      end else begin : g_mid
         assign n_score = out_score[i+1];
         assign n_pos   = out_pos[i+1];
         assign n_valid = out_valid[i+1];
      end

      tka_ins_cell #(.POS_W(POS_W)) u_ins (
         .clock      (clock),
         .reset      (reset),
         .enable     (req_xfer),
         .clear      (req_end_of_vector),
         .new_score  (req_score),
         .new_pos    (count_ff),
         .prev_gt    (p_gt),
         .prev_score (p_score),
         .prev_pos   (p_pos),
         .prev_valid (p_valid),
         .gt         (ins_gt[i]),
         .score      (ins_score[i]),
         .pos        (ins_pos[i]),
         .valid      (ins_valid[i]),
         .nxt_score  (ins_nscore[i]),
         .nxt_pos    (ins_npos[i]),
         .nxt_valid  (ins_nvalid[i])
      );

      tka_out_cell #(.POS_W(POS_W)) u_out (
         .clock      (clock),
         .reset      (reset),
         .load       (end_xfer),
         .shift      (rsp_xfer),
         .load_score (ins_nscore[i]),
         .load_pos   (ins_npos[i]),
         .load_valid (ins_nvalid[i]),
         .next_score (n_score),
         .next_pos   (n_pos),
         .next_valid (n_valid),
         .score      (out_score[i]),
         .pos        (out_pos[i]),
         .valid      (out_valid[i])
      );
   end

   // Front of the output chain; empty ranks read as zero.
   assign rsp_slot_filled = out_valid[0];
   assign rsp_position    = out_valid[0] ? out_pos[0] : '0;
   assign rsp_top_score   = out_valid[0] ? out_score[0] : '0;
   assign rsp_last_rank   = (remain_ff == KW'(1));

   // Filled slots of the insertion chain always form a prefix from rank zero.
   a_ins_prefix: assert property (@(posedge clock) disable iff (reset)
      ((ins_valid & (ins_valid + MAX_K'(1))) == '0))
      else $error("insertion chain has a hole");

   // A last element is taken while results are pending only as the final one leaves.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (end_xfer && rsp_valid) |-> pop_last)
      else $error("ranking loaded over undelivered results");

   // The end of a vector always starts a run of results in the next cycle.
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      end_xfer |=> (rsp_valid && (remain_ff == $past(k_eff))))
      else $error("result run did not start");

   // A pending run never exceeds the number of ranks.
   a_remain_range: assert property (@(posedge clock) disable iff (reset)
      (32'(remain_ff) <= 32'(MAX_K)))
      else $error("result count out of range");

endmodule
